/* hdl/mspv2enc_pkg.sv */
package mspv2enc_pkg;

   // Request type codes as seen on req_type.
   localparam logic REQ_HEADER  = 1'b0;
   localparam logic REQ_PAYLOAD = 1'b1;

   // Fixed header bytes of a native version 2 request.
   localparam logic [7:0] SYNC_DOLLAR = 8'h24;
   localparam logic [7:0] SYNC_X      = 8'h58;
   localparam logic [7:0] SYNC_LT     = 8'h3C;

   // CRC-8 DVB-S2 constants.
   localparam logic [7:0] CRC_POLY = 8'hD5;
   localparam logic [7:0] CRC_TOP  = 8'h80;

   // Result step counter of the back end.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_FIRST     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_CRC_START = 4'd3;
   localparam logic [STEP_W-1:0] STEP_HDR_LAST  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_HDR_CRC   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_PAY_CRC   = 4'd1;

   // Job queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      JOB_HEADER,
      JOB_PAYLOAD,
      JOB_ORPHAN
   } job_kind_type;

   // One classified item, as handed from the front end to the back end.
   typedef struct packed {
      job_kind_type kind;
      logic         err;       // sequence error on every result of this job
      logic         close;     // a CRC byte ends the frame after this job
      logic [7:0]   flags;
      logic [15:0]  command;
      logic [15:0]  length;
      logic [7:0]   data;
   } job_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != 8'h00) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

/* hdl/mspv2enc_front.sv */
module mspv2enc_front
   import mspv2enc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] req_command_code,
   input  logic [7:0]  req_frame_flags,
   input  logic [15:0] req_payload_length,
   input  logic [7:0]  req_data_byte,
   input  logic        queue_full,
   output logic        push,
   output job_type     push_job
);

   logic        frame_open_ff, frame_open_in;
   logic [15:0] remaining_ff, remaining_in;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      frame_open_in     = frame_open_ff;
      remaining_in      = remaining_ff;
      push_job.kind     = JOB_ORPHAN;
      push_job.err      = 1'b1;
      push_job.close    = 1'b0;
      push_job.flags    = req_frame_flags;
      push_job.command  = req_command_code;
      push_job.length   = req_payload_length;
      push_job.data     = req_data_byte;
      unique case (req_type)
         REQ_HEADER: begin
            // A header while a frame is open abandons that frame.
            push_job.kind  = JOB_HEADER;
            push_job.err   = frame_open_ff;
            push_job.close = (req_payload_length == 16'd0);
            if (push) begin
               frame_open_in = (req_payload_length != 16'd0);
               remaining_in  = req_payload_length;
            end
         end
         default: begin
            if (frame_open_ff) begin
               push_job.kind  = JOB_PAYLOAD;
               push_job.err   = 1'b0;
               push_job.close = (remaining_ff == 16'd1);
               if (push) begin
                  remaining_in = remaining_ff - 16'd1;
                  if (remaining_ff == 16'd1) begin
                     frame_open_in = 1'b0;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         remaining_ff  <= 16'd0;
      end else begin
         frame_open_ff <= frame_open_in;
         remaining_ff  <= remaining_in;
      end
   end

endmodule

/* hdl/mspv2enc_queue.sv */
module mspv2enc_queue
   import mspv2enc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type             mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

/* hdl/mspv2enc_back.sv */
module mspv2enc_back
   import mspv2enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_frame_end,
   output logic       rsp_run_last,
   output logic       rsp_sequence_error
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [7:0]        crc_ff, crc_in;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff;
   logic              bvalid_ff, end_ff, last_ff, err_ff;

   logic       load;
   logic [7:0] res_byte;
   logic       res_bvalid, res_end, res_last;
   logic [7:0] crc_base;
   logic [7:0] crc_upd;

   assign load = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      res_byte   = 8'h00;
      res_bvalid = 1'b0;
      res_end    = 1'b0;
      res_last   = 1'b0;
      crc_base   = crc_ff;
      crc_upd    = crc_ff;
      unique case (head_job.kind)
         JOB_HEADER: begin
            if (step_ff == STEP_HDR_CRC) begin
               res_byte   = crc_ff;
               res_bvalid = 1'b1;
               res_end    = 1'b1;
               res_last   = 1'b1;
               crc_upd    = 8'h00;
            end else begin
               unique case (step_ff[2:0])
                  3'd0: res_byte = SYNC_DOLLAR;
                  3'd1: res_byte = SYNC_X;
                  3'd2: res_byte = SYNC_LT;
                  3'd3: res_byte = head_job.flags;
                  3'd4: res_byte = head_job.command[7:0];
                  3'd5: res_byte = head_job.command[15:8];
                  3'd6: res_byte = head_job.length[7:0];
                  default: res_byte = head_job.length[15:8];
               endcase
               res_bvalid = 1'b1;
               res_last   = (step_ff == STEP_HDR_LAST) && !head_job.close;
               // The checksum restarts with every header and covers the
               // flags byte onward.
               if (step_ff == STEP_FIRST) begin
                  crc_base = 8'h00;
               end
               crc_upd = (step_ff >= STEP_CRC_START) ? crc8_update(crc_base, res_byte)
                                                     : crc_base;
            end
         end
         JOB_PAYLOAD: begin
            res_bvalid = 1'b1;
            if (step_ff == STEP_PAY_CRC) begin
               res_byte = crc_ff;
               res_end  = 1'b1;
               res_last = 1'b1;
               crc_upd  = 8'h00;
            end else begin
               res_byte = head_job.data;
               res_last = !head_job.close;
               crc_upd  = crc8_update(crc_ff, head_job.data);
            end
         end
         default: begin
            res_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      pop      = load && res_last;
      step_in  = step_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = res_last ? STEP_FIRST : step_ff + 1'b1;
         crc_in   = crc_upd;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_FIRST;
         crc_ff   <= 8'h00;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= res_byte;
         bvalid_ff <= res_bvalid;
         end_ff    <= res_end;
         last_ff   <= res_last;
         err_ff    <= head_job.err;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_byte_valid     = bvalid_ff;
   assign rsp_frame_end      = end_ff;
   assign rsp_run_last       = last_ff;
   assign rsp_sequence_error = err_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_byte_valid && rsp_run_last)
      else $error("checksum byte not marked as a frame byte ending its item");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |->
         rsp_sequence_error && rsp_run_last && (rsp_out_byte == 8'h00))
      else $error("empty result is not a lone error result");
   assert property (@(posedge clock) disable iff (reset)
      pop |=> step_ff == STEP_FIRST)
      else $error("step counter not rewound after a job");
   assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_HDR_CRC)
      else $error("step counter out of range");
`endif

endmodule

/* hdl/mspv2_frame_encoder_top.sv */
// Channel   Direction  Handshake             Transfer carries
// req_      in         req_valid/req_ready   one header item or one payload byte item
// rsp_      out        rsp_valid/rsp_ready   one frame byte or one error result
//
// A payload byte item yields one result in the back end, or two when its byte closes
// the frame. A header item yields eight results, or nine with a zero length. The back
// end's single output register hands out one result a cycle while rsp_ready is high.
// A four-entry job queue lets the input side keep taking items while a header is
// still being expanded. Reset is synchronous and active high and empties the queue
// and closes any frame. Either side may stall at any time; nothing is lost.
module mspv2_frame_encoder_top
   import mspv2enc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] req_command_code,
   input  logic [7:0]  req_frame_flags,
   input  logic [15:0] req_payload_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_frame_end,
   output logic        rsp_run_last,
   output logic        rsp_sequence_error
);

   // The front end tracks whether a frame is open and how many payload bytes are
   // still due, and turns every accepted transfer into one classified job.
   logic    push, full, pop, head_valid;
   job_type push_job, head_job;

   mspv2enc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_command_code   (req_command_code),
      .req_frame_flags    (req_frame_flags),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .queue_full         (full),
      .push               (push),
      .push_job           (push_job)
   );

   // The queue decouples classification from byte generation, so each side
   // stalls on its own.
   mspv2enc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // The back end expands each job into its result bytes, runs the CRC-8 over
   // them from the flags byte on and holds each result in an output register until it is taken.
   mspv2enc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_job           (head_job),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_run_last       (rsp_run_last),
      .rsp_sequence_error (rsp_sequence_error)
   );

endmodule
